// ===== rtl/ows_pkg.sv =====
// ----------------------------------------------------------------------------
// ows_pkg
// Types and constants for the 1-Wire Search ROM engine.
// ----------------------------------------------------------------------------
package ows_pkg;

  // number of ROM bits walked in one pass
  localparam logic [6:0] ROM_BITS     = 7'd64;
  // positions below this value fall in the family byte
  localparam logic [6:0] FAMILY_LIMIT = 7'd9;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_BEGIN = 2'd1,
    REQ_BIT   = 2'd2
  } ows_req_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_FOUND  = 2'd1,
    ST_NO_DEV = 2'd2,
    ST_FAIL   = 2'd3
  } ows_status_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
  } ows_in_t;

  typedef struct packed {
    logic        write_valid;
    logic        direction_bit;
    logic [1:0]  pass_status;
    logic [63:0] rom_value;
    logic [3:0]  family_discrepancy;
    logic        last_device;
    logic [7:0]  device_count;
  } ows_out_t;

endpackage

// ===== rtl/onewire_rom_search_engine.sv =====
// ----------------------------------------------------------------------------
// onewire_rom_search_engine
// Master side of the 1-Wire Search ROM walk: one direction result per request.
// ----------------------------------------------------------------------------
//  channel | signals                     | payload
//  --------+-----------------------------+----------------------------------
//  request | req_valid, req_stall, req   | ows_in_t: type, presence, bit pair
//  result  | rsp_valid, rsp_stall, rsp   | ows_out_t: direction, status, rom
//
//  one transaction per cycle when no result is stalled; a request is taken
//  into an input register and its result is then registered in the output
//  register. the search state loop is a single compare and update per cycle.
//  synchronous reset clears the search state and the device counter.
//  a stalled result holds; the input register keeps taking requests until
//  both registers are full.
// ----------------------------------------------------------------------------
module onewire_rom_search_engine import ows_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  ows_in_t  req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output ows_out_t rsp
);

  logic     hold_valid;
  ows_in_t  hold;
  logic     advance;
  logic     step;
  logic     accept;
  ows_out_t result;

  assign advance   = !rsp_valid || !rsp_stall;
  assign req_stall = hold_valid && !advance;
  assign accept    = req_valid && !req_stall;
  assign step      = hold_valid && advance;

  ows_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .req    (hold),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (accept) begin
        hold_valid <= 1'b1;
      end else if (advance) begin
        hold_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= hold_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= req;
    end
    if (step) begin
      rsp <= result;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (hold_valid && rsp_valid))
    else $error("request stalled with a free register");

  a_dir_only_when_written: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.write_valid) |-> !rsp.direction_bit)
    else $error("direction bit set without a write");

  a_write_not_no_dev: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.write_valid) |-> (rsp.pass_status != ST_NO_DEV))
    else $error("bit write reported with no-device status");

  a_family_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.family_discrepancy <= 4'd8))
    else $error("family discrepancy beyond family byte");

endmodule

// ===== rtl/ows_core.sv =====
// ----------------------------------------------------------------------------
// ows_core
// Search state registers and the per-transaction branch choice and update.
// ----------------------------------------------------------------------------
module ows_core import ows_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  ows_in_t  req,
  output ows_out_t result
);

  logic [63:0] rom_id, rom_id_next;
  logic [6:0]  bit_position, bit_position_next;
  logic [6:0]  last_discrepancy, last_discrepancy_next;
  logic [6:0]  last_zero_pos, last_zero_pos_next;
  logic [3:0]  family_disc, family_disc_next;
  logic        last_device_flag, last_device_flag_next;
  logic        pass_active, pass_active_next;
  logic [7:0]  found_count, found_count_next;

  logic        dir;
  logic        wvalid;
  logic [1:0]  status;
  logic [5:0]  idx;
  logic [6:0]  bp_inc;

  assign idx    = bit_position[5:0] - 6'd1;
  assign bp_inc = bit_position + 7'd1;

  always_comb begin
    rom_id_next           = rom_id;
    bit_position_next     = bit_position;
    last_discrepancy_next = last_discrepancy;
    last_zero_pos_next    = last_zero_pos;
    family_disc_next      = family_disc;
    last_device_flag_next = last_device_flag;
    pass_active_next      = pass_active;
    found_count_next      = found_count;
    dir    = 1'b0;
    wvalid = 1'b0;
    status = ST_IDLE;
    case (req.req_type)
      REQ_CLEAR: begin
        last_discrepancy_next = '0;
        family_disc_next      = '0;
        last_device_flag_next = 1'b0;
        pass_active_next      = 1'b0;
        bit_position_next     = 7'd1;
      end
      REQ_BEGIN: begin
        if (last_device_flag || !req.presence) begin
          last_discrepancy_next = '0;
          family_disc_next      = '0;
          last_device_flag_next = 1'b0;
          pass_active_next      = 1'b0;
          status                = ST_NO_DEV;
        end else begin
          pass_active_next   = 1'b1;
          bit_position_next  = 7'd1;
          last_zero_pos_next = '0;
        end
      end
      REQ_BIT: begin
        if (pass_active) begin
          if (req.id_bit && req.complement_bit) begin
            last_discrepancy_next = '0;
            family_disc_next      = '0;
            last_device_flag_next = 1'b0;
            pass_active_next      = 1'b0;
            status                = ST_FAIL;
          end else begin
            if (req.id_bit != req.complement_bit) begin
              dir = req.id_bit;
            end else begin
              // discrepancy: follow old path below, take 1 at, 0 beyond
              if (bit_position < last_discrepancy) begin
                dir = rom_id[idx];
              end else begin
                dir = (bit_position == last_discrepancy);
              end
              if (!dir) begin
                last_zero_pos_next = bit_position;
                if (bit_position < FAMILY_LIMIT) begin
                  family_disc_next = bit_position[3:0];
                end
              end
            end
            rom_id_next[idx]  = dir;
            wvalid            = 1'b1;
            bit_position_next = bp_inc;
            if (bp_inc > ROM_BITS) begin
              pass_active_next      = 1'b0;
              last_discrepancy_next = last_zero_pos_next;
              last_device_flag_next = (last_zero_pos_next == 7'd0);
              if (rom_id_next[7:0] == 8'd0) begin
                last_discrepancy_next = '0;
                family_disc_next      = '0;
                last_device_flag_next = 1'b0;
                status                = ST_FAIL;
              end else begin
                found_count_next = found_count + 8'd1;
                status           = ST_FOUND;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.write_valid        = wvalid;
    result.direction_bit      = dir;
    result.pass_status        = status;
    result.rom_value          = rom_id_next;
    result.family_discrepancy = family_disc_next;
    result.last_device        = last_device_flag_next;
    result.device_count       = found_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_id           <= '0;
      bit_position     <= 7'd1;
      last_discrepancy <= '0;
      last_zero_pos    <= '0;
      family_disc      <= '0;
      last_device_flag <= 1'b0;
      pass_active      <= 1'b0;
      found_count      <= '0;
    end else if (step) begin
      rom_id           <= rom_id_next;
      bit_position     <= bit_position_next;
      last_discrepancy <= last_discrepancy_next;
      last_zero_pos    <= last_zero_pos_next;
      family_disc      <= family_disc_next;
      last_device_flag <= last_device_flag_next;
      pass_active      <= pass_active_next;
      found_count      <= found_count_next;
    end
  end

endmodule
